FILE: src/wsdf_pkg.sv
// shared types and constants for the websocket deframer
`timescale 1ns / 1ps
package wsdf_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_CLOSE   = 2'd2,
    KIND_REFUSED = 2'd3
  } wsdf_kind_t;

  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_CNT = 4'd2;
  localparam logic [3:0] EXT64_CNT = 4'd8;
  localparam logic [3:0] KEY_CNT   = 4'd4;

  // one classified word handed from the parser to the output stage
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    wsdf_kind_t kind;
    logic       last;
  } wsdf_cmd_t;

endpackage

FILE: src/wsdf_front.sv
// header parser: tracks frame phase and classifies each incoming word
`timescale 1ns / 1ps
module wsdf_front #(
  parameter int LENGTH_BITS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              push,
  output wsdf_pkg::wsdf_cmd_t push_cmd
);
  import wsdf_pkg::*;

  typedef enum logic [5:0] {
    PH_HDR0   = 6'b000001,
    PH_HDR1   = 6'b000010,
    PH_EXT    = 6'b000100,
    PH_KEY    = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_CLOSED = 6'b100000
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   mask_present_r, mask_present_nxt;
  logic [3:0]             hdr_cnt_r, hdr_cnt_nxt;
  logic [LENGTH_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [31:0]            mask_key_r, mask_key_nxt;
  logic [1:0]             key_index_r, key_index_nxt;

  logic                   accept;
  logic [7:0]             key_byte;
  logic [LENGTH_BITS-1:0] len7_ext;

  assign accept   = in_valid & in_ready;
  assign len7_ext = {{(LENGTH_BITS-7){1'b0}}, in_byte[6:0]};

  always_comb begin
    unique case (key_index_r)
      2'd0: key_byte = mask_key_r[31:24];
      2'd1: key_byte = mask_key_r[23:16];
      2'd2: key_byte = mask_key_r[15:8];
      2'd3: key_byte = mask_key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt        = phase_r;
    opcode_nxt       = opcode_r;
    mask_present_nxt = mask_present_r;
    hdr_cnt_nxt      = hdr_cnt_r;
    bytes_left_nxt   = bytes_left_r;
    mask_key_nxt     = mask_key_r;
    key_index_nxt    = key_index_r;
    push             = 1'b0;
    push_cmd.data    = 8'd0;
    push_cmd.key     = 8'd0;
    push_cmd.kind    = KIND_PAYLOAD;
    push_cmd.last    = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_HDR1: begin
          mask_present_nxt = in_byte[7];
          if (opcode_r == OP_CLOSE) begin
            phase_nxt     = PH_CLOSED;
            push          = 1'b1;
            push_cmd.kind = KIND_CLOSE;
          end else if (in_byte[6:0] == LEN_EXT16) begin
            bytes_left_nxt = '0;
            hdr_cnt_nxt    = EXT16_CNT;
            phase_nxt      = PH_EXT;
          end else if (in_byte[6:0] == LEN_EXT64) begin
            bytes_left_nxt = '0;
            hdr_cnt_nxt    = EXT64_CNT;
            phase_nxt      = PH_EXT;
          end else begin
            bytes_left_nxt = len7_ext;
            key_index_nxt  = 2'd0;
            if (in_byte[7]) begin
              hdr_cnt_nxt = KEY_CNT;
              phase_nxt   = PH_KEY;
            end else begin
              mask_key_nxt = 32'd0;
              if (in_byte[6:0] == 7'd0) begin
                phase_nxt     = PH_HDR0;
                push          = 1'b1;
                push_cmd.kind = KIND_EMPTY;
                push_cmd.last = 1'b1;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end
        end
        PH_EXT: begin
          // saturate once the length no longer fits
          if (|bytes_left_r[LENGTH_BITS-1 -: 8]) begin
            bytes_left_nxt = '1;
          end else begin
            bytes_left_nxt = {bytes_left_r[LENGTH_BITS-9:0], in_byte};
          end
          hdr_cnt_nxt = hdr_cnt_r - 4'd1;
          if (hdr_cnt_r == 4'd1) begin
            key_index_nxt = 2'd0;
            if (mask_present_r) begin
              hdr_cnt_nxt = KEY_CNT;
              phase_nxt   = PH_KEY;
            end else begin
              mask_key_nxt = 32'd0;
              if (bytes_left_nxt == '0) begin
                phase_nxt     = PH_HDR0;
                push          = 1'b1;
                push_cmd.kind = KIND_EMPTY;
                push_cmd.last = 1'b1;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end
        end
        PH_KEY: begin
          mask_key_nxt = {mask_key_r[23:0], in_byte};
          hdr_cnt_nxt  = hdr_cnt_r - 4'd1;
          if (hdr_cnt_r == 4'd1) begin
            if (bytes_left_r == '0) begin
              phase_nxt     = PH_HDR0;
              push          = 1'b1;
              push_cmd.kind = KIND_EMPTY;
              push_cmd.last = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          key_index_nxt  = key_index_r + 2'd1;
          bytes_left_nxt = bytes_left_r - LENGTH_BITS'(1);
          push           = 1'b1;
          push_cmd.data  = in_byte;
          push_cmd.key   = key_byte;
          push_cmd.last  = (bytes_left_r == LENGTH_BITS'(1));
          if (bytes_left_r == LENGTH_BITS'(1)) begin
            phase_nxt = PH_HDR0;
          end
        end
        PH_CLOSED: begin
          push          = 1'b1;
          push_cmd.kind = KIND_REFUSED;
        end
        default: begin
          opcode_nxt = in_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HDR0;
      opcode_r       <= 4'd0;
      mask_present_r <= 1'b0;
      hdr_cnt_r      <= 4'd0;
      bytes_left_r   <= '0;
      mask_key_r     <= 32'd0;
      key_index_r    <= 2'd0;
    end else begin
      phase_r        <= phase_nxt;
      opcode_r       <= opcode_nxt;
      mask_present_r <= mask_present_nxt;
      hdr_cnt_r      <= hdr_cnt_nxt;
      bytes_left_r   <= bytes_left_nxt;
      mask_key_r     <= mask_key_nxt;
      key_index_r    <= key_index_nxt;
    end
  end

endmodule

FILE: src/wsdf_queue.sv
// two-entry queue between the parser and the output stage
`timescale 1ns / 1ps
module wsdf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wsdf_pkg::wsdf_cmd_t push_cmd,
  output logic                not_full,
  input  logic                pop,
  output logic                not_empty,
  output wsdf_pkg::wsdf_cmd_t pop_cmd
);
  import wsdf_pkg::*;

  wsdf_cmd_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: src/wsdf_back.sv
// output stage: applies the mask key and holds the result word
`timescale 1ns / 1ps
module wsdf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  wsdf_pkg::wsdf_cmd_t cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic [1:0]          out_kind,
  output logic                out_last
);
  import wsdf_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  wsdf_kind_t out_kind_r;
  logic       out_last_r;

  assign pop           = cmd_valid & (~out_valid_r | out_ready);
  assign out_valid_nxt = pop | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r <= cmd.data ^ cmd.key;
      out_kind_r <= cmd.kind;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

endmodule

FILE: src/websocket_frame_deframer_unmask.sv
// top level of the websocket frame deframer with payload unmasking
//
// input channel: one stream byte per word on in_byte, in_valid/in_ready.
// output channel: out_byte, out_kind, out_last with out_valid/out_ready.
//   out_kind 0 payload byte (unmasked), 1 empty message, 2 close received,
//   3 refused while closed; out_byte is zero unless out_kind is 0.
// header, extended length and key bytes give no output word, but a
//   close frame's second header byte gives the close word and the last
//   header byte of an empty message the empty word.
// throughput: one byte per cycle while in_ready is high; the parser
//   state register handles each byte and writes any word into the
//   two-entry queue; the output register takes one word a cycle if free.
// a stalled receiver fills the queue; in_ready drops only when both
//   entries are held, so bytes with no output still wait in that case.
// reset (synchronous, rst_n low) returns the parser to the first header
//   byte, clears the length, key and closed state, and empties the queue.
// after a close frame every byte is answered with a refused word until
//   reset.
`timescale 1ns / 1ps
module websocket_frame_deframer_unmask #(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last
);
  import wsdf_pkg::*;

  logic      push;
  wsdf_cmd_t push_cmd;
  logic      pop;
  logic      q_not_empty;
  wsdf_cmd_t pop_cmd;

  wsdf_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .push     (push),
    .push_cmd (push_cmd)
  );

  wsdf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .not_full  (in_ready),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_cmd   (pop_cmd)
  );

  wsdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd       (pop_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

  a_nonpayload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |-> out_byte == 8'd0)
    else $error("non-payload word carries data");

  a_close_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_CLOSE || out_kind == KIND_REFUSED) |-> !out_last)
    else $error("close or refused word marked last");

  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_kind == KIND_CLOSE || out_kind == KIND_REFUSED)
    |=> !out_valid || out_kind == KIND_REFUSED)
    else $error("word other than refused after close");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EMPTY |-> out_last)
    else $error("empty message not marked last");

endmodule

FILE: verif/tb_top.sv
// testbench for the websocket frame deframer: random frames checked against a scoreboard
`timescale 1ns / 1ps
module tb_top;
  import wsdf_pkg::*;

  localparam int LEN_W = 64;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam int LIMIT = 200000;
  localparam int FORM_SHORT = 0;
  localparam int FORM_EXT16 = 1;
  localparam int FORM_EXT64 = 2;

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXT    = 3'd2,
    PH_KEY    = 3'd3,
    PH_DATA   = 3'd4,
    PH_CLOSED = 3'd5
  } parse_phase_t;

  typedef struct {
    logic [7:0] data;
    wsdf_kind_t kind;
    logic       last;
  } ws_word_t;

  class deframe_scoreboard;
    parse_phase_t     phase;
    logic [3:0]       opcode;
    logic             masked;
    logic [3:0]       hdr_left;
    logic [LEN_W-1:0] pay_left;
    logic [31:0]      key;
    logic [1:0]       key_pos;
    ws_word_t         expected_words[$];
    int               errors;

    function new();
      phase = PH_HDR0;
      opcode = '0;
      masked = 1'b0;
      hdr_left = '0;
      pay_left = '0;
      key = '0;
      key_pos = '0;
      errors = 0;
    endfunction

    function void queue_word(logic [7:0] d, wsdf_kind_t k, logic l);
      ws_word_t w;
      w.data = d;
      w.kind = k;
      w.last = l;
      expected_words = {expected_words, w};
    endfunction

    // length known: key bytes next, payload next, or an empty message now
    function void header_done();
      key_pos = '0;
      if (masked) begin
        hdr_left = KEY_CNT;
        phase = PH_KEY;
      end else begin
        key = '0;
        if (pay_left == '0) begin
          phase = PH_HDR0;
          queue_word(8'h00, KIND_EMPTY, 1'b1);
        end else begin
          phase = PH_DATA;
        end
      end
    endfunction

    function void record_byte(logic [7:0] b);
      logic [7:0] kb;
      case (phase)
        PH_HDR1: begin
          masked = b[7];
          if (opcode == OP_CLOSE) begin
            phase = PH_CLOSED;
            queue_word(8'h00, KIND_CLOSE, 1'b0);
          end else begin
            pay_left = '0;
            if (b[6:0] == LEN_EXT16) begin
              hdr_left = EXT16_CNT;
              phase = PH_EXT;
            end else if (b[6:0] == LEN_EXT64) begin
              hdr_left = EXT64_CNT;
              phase = PH_EXT;
            end else begin
              pay_left = LEN_W'(b[6:0]);
              header_done();
            end
          end
        end
        PH_EXT: begin
          if (pay_left > (LEN_MAX >> 8)) pay_left = LEN_MAX;
          else pay_left = {pay_left[LEN_W-9:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == '0) header_done();
        end
        PH_KEY: begin
          key = {key[23:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == '0) begin
            if (pay_left == '0) begin
              phase = PH_HDR0;
              queue_word(8'h00, KIND_EMPTY, 1'b1);
            end else begin
              phase = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          kb = key[8 * (3 - int'(key_pos)) +: 8];
          key_pos = key_pos + 2'd1;
          pay_left = pay_left - 1'b1;
          if (pay_left == '0) phase = PH_HDR0;
          queue_word(b ^ kb, KIND_PAYLOAD, pay_left == '0);
        end
        PH_CLOSED: queue_word(8'h00, KIND_REFUSED, 1'b0);
        default: begin
          opcode = b[3:0];
          phase = PH_HDR1;
        end
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_word(logic [7:0] d, logic [1:0] k, logic l);
      ws_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word byte=%02h kind=%0d last=%0b", d, k, l));
      end else begin
        w = expected_words.pop_front();
        if (w.data !== d || w.kind !== k || w.last !== l)
          report($sformatf("exp byte=%02h kind=%0d last=%0b, got byte=%02h kind=%0d last=%0b",
                           w.data, w.kind, w.last, d, k, l));
      end
    endfunction

    function void flush_leftover();
      while (expected_words.size() != 0) begin
        void'(expected_words.pop_front());
        report("expected word never arrived");
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;

  deframe_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int sent;
  int cycles;

  websocket_frame_deframer_unmask #(.LENGTH_BITS(LEN_W)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_kind (out_kind),
    .out_last (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_byte, out_kind, out_last);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.record_byte(b);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [3:0] op, input logic msk, input int len,
                            input int form, input logic [31:0] key);
    logic [63:0] ext;
    ext = 64'(len);
    send_byte({4'($urandom), op});
    case (form)
      FORM_SHORT: send_byte({msk, 7'(len)});
      FORM_EXT16: begin
        send_byte({msk, LEN_EXT16});
        for (int i = 1; i >= 0; i--) send_byte(ext[8*i +: 8]);
      end
      default: begin
        send_byte({msk, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(ext[8*i +: 8]);
      end
    endcase
    if (msk) for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    for (int i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  task automatic random_frame();
    logic [3:0] op;
    int r;
    do op = 4'($urandom_range(15)); while (op == OP_CLOSE);
    r = $urandom_range(99);
    if (r < 5)
      send_frame(op, 1'($urandom), $urandom_range(125, 100), FORM_SHORT, $urandom);
    else if (r < 70)
      send_frame(op, 1'($urandom), $urandom_range(20), FORM_SHORT, $urandom);
    else if (r < 90)
      send_frame(op, 1'($urandom), $urandom_range(300), FORM_EXT16, $urandom);
    else
      send_frame(op, 1'($urandom), $urandom_range(40), FORM_EXT64, $urandom);
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int start;
    idle_tab = '{0, 67, 0, 38};
    stall_tab = '{0, 0, 67, 38};
    sb = new();
    idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    out_ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty frames, masked payload, both extended length forms
    send_frame(4'h1, 1'b0, 0, FORM_SHORT, 32'h0);
    send_frame(4'h2, 1'b1, 0, FORM_SHORT, 32'hFFFF_FFFF);
    send_frame(4'h0, 1'b1, 3, FORM_SHORT, 32'hA5C3_0FF0);
    send_frame(4'hF, 1'b0, 1, FORM_EXT16, 32'h0);
    send_frame(4'h9, 1'b0, 0, FORM_EXT64, 32'h0);

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_tab[p];
      stall_pct = stall_tab[p];
      start = sent;
      while (sent - start < 300) random_frame();
    end

    // close frame, then everything is refused
    send_byte({4'($urandom), OP_CLOSE});
    send_byte({1'b1, LEN_EXT64});
    send_byte(8'h00);
    send_byte(8'hFF);
    repeat (20) send_byte(8'($urandom));
    in_valid <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.flush_leftover();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
